### hw/rtl/sawc_pkg.sv
// Shared types and constants for the set-associative write-back cache.
// Depends on nothing; used by the cache, its checker and the testbench.
package sawc_pkg;
  localparam int unsigned SIZE_WIDTH_DEF   = 14;
  localparam int unsigned WAY_WIDTH_DEF    = 2;
  localparam int unsigned OFFSET_WIDTH_DEF = 6;
  localparam logic [15:0] LFSR_SEED = 16'hACE1;

  typedef enum logic [1:0] {
    REQ_READ  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_FILL  = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WDONE = 2'd1,
    KIND_WBACK = 2'd2,
    KIND_FETCH = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_WBACK,
    ST_FETCH,
    ST_WAIT,
    ST_FINRD,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] rdata;
    logic        hit;
    logic [25:0] mem_block;
    logic [31:0] mem_word;
    logic        last;
  } result_t;

  function automatic logic [15:0] lfsr_step(input logic [15:0] l);
    logic b;
    b = l[0] ^ l[2] ^ l[3] ^ l[5];
    return {b, l[15:1]};
  endfunction
endpackage

### hw/rtl/sawc_if.sv
// Valid/ready channel interfaces for the cache's request and result items.
// Depends on nothing; the result fields mirror the sawc_pkg result struct.
interface sawc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [31:0] addr;
  logic [31:0] wdata;
  logic [31:0] wmask;
  logic [31:0] fill_word;
  modport source (output valid, req_type, addr, wdata, wmask, fill_word, input ready);
  modport sink   (input valid, req_type, addr, wdata, wmask, fill_word, output ready);
endinterface

interface sawc_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] rdata;
  logic        hit;
  logic [25:0] mem_block;
  logic [31:0] mem_word;
  logic        last;
  modport source (output valid, kind, rdata, hit, mem_block, mem_word, last, input ready);
  modport sink   (input valid, kind, rdata, hit, mem_block, mem_word, last, output ready);
endinterface

### hw/rtl/set_assoc_writeback_cache.sv
// Channel     | Dir | Payload
// in          | in  | req_type, addr, wdata, wmask, fill_word
// out         | out | kind, rdata, hit, mem_block, mem_word, last
// A hit runs a tag scan over the ways in order (LOOKUP), one data read (FINRD),
// and the merge and result register (FINISH); the next item is then taken in
// IDLE. A miss scans every way; a dirty victim is then written back (one RAM
// read ahead, then one writeback word per cycle unless the result stalls), a
// clean one skips this. The fetch follows, then 16 fill items, FINRD and FINISH.
// Reset is synchronous and clears valid/dirty flip-flops, the LFSR and control.
// A stalled result holds WBACK, FETCH and FINISH; while a miss is pending only
// fill items are consumed, and reads and writes are taken and dropped.
// Depends on sawc_pkg, sawc_if and sawc_ram.
module set_assoc_writeback_cache #(
  parameter int unsigned SIZE_WIDTH   = sawc_pkg::SIZE_WIDTH_DEF,
  parameter int unsigned WAY_WIDTH    = sawc_pkg::WAY_WIDTH_DEF,
  parameter int unsigned OFFSET_WIDTH = sawc_pkg::OFFSET_WIDTH_DEF
) (
  input logic        clk,
  input logic        rst_n,
  sawc_req_if.sink   in_ch,
  sawc_res_if.source out_ch
);
  localparam int unsigned SET_WIDTH = SIZE_WIDTH - WAY_WIDTH - OFFSET_WIDTH;
  localparam int unsigned TAG_BITS  = 32 - SET_WIDTH - OFFSET_WIDTH;
  localparam int unsigned WOFF_W    = OFFSET_WIDTH - 2;
  localparam int unsigned WORDS     = 1 << WOFF_W;
  localparam int unsigned WAYS      = 1 << WAY_WIDTH;
  localparam int unsigned LINE_W    = SET_WIDTH + WAY_WIDTH;
  localparam int unsigned LINES     = 1 << LINE_W;
  localparam int unsigned DADDR_W   = LINE_W + WOFF_W;
  localparam int unsigned WAYI_W    = (WAY_WIDTH > 0) ? WAY_WIDTH : 1;

  sawc_pkg::state_t state_r, state_nxt;

  logic [LINES-1:0] valid_r, dirty_r;
  logic [15:0]      lfsr_r;
  logic [1:0]       ptype_r;
  logic [31:0]      paddr_r, pwdata_r, pwmask_r;
  logic [WAYI_W-1:0] pway_r;
  logic [WAYI_W:0]  wcnt_r;            // way scan counter during lookup
  logic [WOFF_W:0]  cnt_r;             // word counter for writeback and fill
  logic             found_r;
  logic             wb_vld_r;
  sawc_pkg::result_t res_r;
  logic             res_vld_r;
  logic             res_load;

  logic [SET_WIDTH-1:0] pset;
  logic [TAG_BITS-1:0]  ptag;
  assign pset = paddr_r[OFFSET_WIDTH +: SET_WIDTH];
  assign ptag = paddr_r[31 -: TAG_BITS];

  // Tag RAM.
  logic                tag_we;
  logic [LINE_W-1:0]   tag_addr;
  logic [TAG_BITS-1:0] tag_rd;
  sawc_ram #(.WIDTH(TAG_BITS), .DEPTH(LINES)) u_tag (
    .clk(clk), .we(tag_we), .addr(tag_addr), .wdata(ptag), .rdata(tag_rd));

  // Data RAM.
  logic               dat_we;
  logic [DADDR_W-1:0] dat_addr;
  logic [31:0]        dat_wd, dat_rd;
  sawc_ram #(.WIDTH(32), .DEPTH(LINES * WORDS)) u_data (
    .clk(clk), .we(dat_we), .addr(dat_addr), .wdata(dat_wd), .rdata(dat_rd));

  logic [LINE_W-1:0] scan_line, pline;
  logic [WAYI_W-1:0] scan_way;
  assign scan_way  = wcnt_r[WAYI_W-1:0];
  assign scan_line = LINE_W'({pset, scan_way} >> (WAYI_W - WAY_WIDTH));
  assign pline     = LINE_W'({pset, pway_r} >> (WAYI_W - WAY_WIDTH));

  logic out_free;
  assign out_free = !res_vld_r || out_ch.ready;
  logic in_fire;
  assign in_fire = in_ch.valid && in_ch.ready;

  logic [15:0] lfsr_nx;
  assign lfsr_nx = sawc_pkg::lfsr_step(lfsr_r);

  // Lookup checks the tag of the way read in the previous cycle.
  logic [WAYI_W-1:0] prev_way;
  logic [LINE_W-1:0] prev_line;
  assign prev_way  = WAYI_W'(wcnt_r - 1'b1);
  assign prev_line = LINE_W'({pset, prev_way} >> (WAYI_W - WAY_WIDTH));
  logic prev_hit;
  assign prev_hit = (wcnt_r != '0) && valid_r[prev_line] && (tag_rd == ptag);

  logic [WAYI_W-1:0] free_way;
  logic              any_free;
  always_comb begin
    logic [LINE_W-1:0] l;
    free_way = '0;
    any_free = 1'b0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      l = LINE_W'({pset, WAYI_W'(w)} >> (WAYI_W - WAY_WIDTH));
      if (!valid_r[l]) begin
        free_way = WAYI_W'(w);
        any_free = 1'b1;
      end
    end
  end

  logic [WAYI_W-1:0] vict_way;
  assign vict_way = any_free ? free_way : (lfsr_nx[WAYI_W-1:0] & WAYI_W'(WAYS - 1));

  logic vict_dirty;
  assign vict_dirty = valid_r[pline] && dirty_r[pline];

  logic [DADDR_W-1:0] word_addr;
  assign word_addr = {pline, paddr_r[2 +: WOFF_W]};

  always_comb begin
    state_nxt = state_r;
    in_ch.ready = 1'b0;
    res_load = 1'b0;
    tag_we = 1'b0;
    tag_addr = scan_line;
    dat_we = 1'b0;
    dat_addr = word_addr;
    dat_wd = in_ch.fill_word;
    unique case (state_r)
      sawc_pkg::ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_fire && (in_ch.req_type == sawc_pkg::REQ_READ ||
                        in_ch.req_type == sawc_pkg::REQ_WRITE)) begin
          state_nxt = sawc_pkg::ST_LOOKUP;
        end
      end
      sawc_pkg::ST_LOOKUP: begin
        tag_addr = scan_line;
        if (prev_hit) begin
          state_nxt = sawc_pkg::ST_FINRD;
        end else if (wcnt_r == (WAYI_W+1)'(WAYS)) begin
          state_nxt = sawc_pkg::ST_WBACK;
        end
      end
      sawc_pkg::ST_WBACK: begin
        tag_addr = pline;
        // While the word in hand is stalled, re-read it so the RAM output holds.
        if (wb_vld_r && !out_free) begin
          dat_addr = {pline, WOFF_W'(cnt_r - 1'b1)};
        end else begin
          dat_addr = {pline, cnt_r[WOFF_W-1:0]};
        end
        res_load = vict_dirty && wb_vld_r && out_free;
        if (!vict_dirty) begin
          state_nxt = sawc_pkg::ST_FETCH;
        end else if (res_load && cnt_r == (WOFF_W+1)'(WORDS)) begin
          state_nxt = sawc_pkg::ST_FETCH;
        end
      end
      sawc_pkg::ST_FETCH: begin
        res_load = out_free;
        if (out_free) state_nxt = sawc_pkg::ST_WAIT;
      end
      sawc_pkg::ST_WAIT: begin
        in_ch.ready = 1'b1;
        dat_addr = {pline, cnt_r[WOFF_W-1:0]};
        dat_we = in_fire && (in_ch.req_type == sawc_pkg::REQ_FILL);
        tag_addr = pline;
        tag_we = dat_we && (cnt_r == (WOFF_W+1)'(WORDS - 1));
        if (tag_we) state_nxt = sawc_pkg::ST_FINRD;
      end
      sawc_pkg::ST_FINRD: state_nxt = sawc_pkg::ST_FINISH;
      sawc_pkg::ST_FINISH: begin
        res_load = out_free;
        dat_we = (ptype_r == sawc_pkg::REQ_WRITE) && out_free;
        dat_wd = (dat_rd & ~pwmask_r) | (pwdata_r & pwmask_r);
        if (out_free) state_nxt = sawc_pkg::ST_IDLE;
      end
      default: state_nxt = sawc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sawc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else if (res_load) begin
      res_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      res_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      dirty_r   <= '0;
      lfsr_r    <= sawc_pkg::LFSR_SEED;
      wb_vld_r  <= 1'b0;
      wcnt_r    <= '0;
      cnt_r     <= '0;
      found_r   <= 1'b0;
    end else begin
      unique case (state_r)
        sawc_pkg::ST_IDLE: begin
          if (in_fire && (in_ch.req_type == sawc_pkg::REQ_READ ||
                          in_ch.req_type == sawc_pkg::REQ_WRITE)) begin
            ptype_r  <= in_ch.req_type;
            paddr_r  <= {in_ch.addr[31:2], 2'b00};
            pwdata_r <= in_ch.wdata;
            pwmask_r <= in_ch.wmask;
            wcnt_r   <= '0;
          end
        end
        sawc_pkg::ST_LOOKUP: begin
          if (prev_hit) begin
            pway_r  <= prev_way;
            found_r <= 1'b1;
          end else if (wcnt_r == (WAYI_W+1)'(WAYS)) begin
            found_r <= 1'b0;
            if (!any_free) lfsr_r <= lfsr_nx;
            pway_r   <= vict_way;
            cnt_r    <= '0;
            wb_vld_r <= 1'b0;
          end else begin
            wcnt_r <= wcnt_r + 1'b1;
          end
        end
        sawc_pkg::ST_WBACK: begin
          // Clean or invalid victims skip the writeback.
          if (vict_dirty) begin
            if (!wb_vld_r) begin
              wb_vld_r <= 1'b1;        // RAM read of word cnt_r now valid next
              cnt_r    <= cnt_r + 1'b1;
            end else if (out_free) begin
              res_r.kind      <= sawc_pkg::KIND_WBACK;
              res_r.rdata     <= '0;
              res_r.hit       <= 1'b0;
              res_r.mem_block <= 26'({tag_rd, pset});
              res_r.mem_word  <= dat_rd;
              res_r.last      <= 1'b0;
              if (cnt_r == (WOFF_W+1)'(WORDS)) begin
                dirty_r[pline] <= 1'b0;
              end else begin
                cnt_r    <= cnt_r + 1'b1;
              end
            end
          end
        end
        sawc_pkg::ST_FETCH: begin
          if (out_free) begin
            valid_r[pline]  <= 1'b0;
            dirty_r[pline]  <= 1'b0;
            res_r.kind      <= sawc_pkg::KIND_FETCH;
            res_r.rdata     <= '0;
            res_r.hit       <= 1'b0;
            res_r.mem_block <= 26'(paddr_r >> OFFSET_WIDTH);
            res_r.mem_word  <= '0;
            res_r.last      <= 1'b1;
            cnt_r           <= '0;
          end
        end
        sawc_pkg::ST_WAIT: begin
          if (dat_we) begin
            if (cnt_r == (WOFF_W+1)'(WORDS - 1)) begin
              valid_r[pline] <= 1'b1;
            end else begin
              cnt_r <= cnt_r + 1'b1;
            end
          end
        end
        sawc_pkg::ST_FINRD:  ;
        sawc_pkg::ST_FINISH: begin
          if (out_free) begin
            if (ptype_r == sawc_pkg::REQ_WRITE) dirty_r[pline] <= 1'b1;
            res_r.kind      <= (ptype_r == sawc_pkg::REQ_WRITE) ?
                               sawc_pkg::KIND_WDONE : sawc_pkg::KIND_READ;
            res_r.rdata     <= (ptype_r == sawc_pkg::REQ_WRITE) ? '0 : dat_rd;
            res_r.hit       <= found_r;
            res_r.mem_block <= '0;
            res_r.mem_word  <= '0;
            res_r.last      <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_ch.valid     = res_vld_r;
  assign out_ch.kind      = res_r.kind;
  assign out_ch.rdata     = res_r.rdata;
  assign out_ch.hit       = res_r.hit;
  assign out_ch.mem_block = res_r.mem_block;
  assign out_ch.mem_word  = res_r.mem_word;
  assign out_ch.last      = res_r.last;
endmodule

### hw/rtl/sawc_ram.sv
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
module sawc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

### hw/rtl/sawc_checker.sv
// Port-level checks for the cache's result channel.
// Depends on sawc_pkg and set_assoc_writeback_cache; bound to it below.
module sawc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        ovalid,
  input logic        oready,
  input logic [1:0]  okind,
  input logic        ohit,
  input logic        olast,
  input logic [31:0] ordata
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid && !oready |=> ovalid && $stable(okind))
    else $error("result changed while stalled");
  a_wb_last: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid && okind == sawc_pkg::KIND_WBACK |-> !olast && !ohit)
    else $error("writeback word flagged last or hit");
  a_fetch_last: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid && okind == sawc_pkg::KIND_FETCH |-> olast && !ohit && ordata == '0)
    else $error("bad fetch result");
  a_resp_last: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid && (okind == sawc_pkg::KIND_READ || okind == sawc_pkg::KIND_WDONE) |-> olast)
    else $error("response not last");
endmodule

bind set_assoc_writeback_cache sawc_checker u_sawc_checker (
  .clk(clk), .rst_n(rst_n), .ovalid(out_ch.valid), .oready(out_ch.ready),
  .okind(out_ch.kind), .ohit(out_ch.hit), .olast(out_ch.last),
  .ordata(out_ch.rdata));

### tb/set_assoc_writeback_cache_tb.sv
// Self-checking testbench for the set-associative write-back cache.
// Depends on sawc_pkg, sawc_if and the set_assoc_writeback_cache RTL.
// A behavioral cache model predicts every result item, and a monitor checks them.
module set_assoc_writeback_cache_tb;
  localparam int WORDS   = 16;
  localparam int WAYS    = 4;
  localparam int LINES   = 256;

  typedef struct {
    sawc_pkg::req_t rt;
    logic [31:0] addr;
    logic [31:0] wdata;
    logic [31:0] wmask;
    logic [31:0] fill;
  } access_t;

  logic clk;
  logic rst_n;

  sawc_req_if in_ch ();
  sawc_res_if out_ch ();

  set_assoc_writeback_cache dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Shadow copy of the cache contents and miss bookkeeping.
  logic [19:0] shadow_tag [LINES];
  logic        shadow_valid [LINES];
  logic        shadow_dirty [LINES];
  logic [31:0] shadow_data [LINES*WORDS];
  logic [15:0] victim_lfsr;
  logic        miss_busy;
  access_t     miss_access;
  int unsigned miss_way;
  int unsigned fill_idx;

  sawc_pkg::result_t expected_results [$];
  access_t     pending_items [$];
  access_t     cur_item;
  logic        holding;
  int          gap_left, burst_left;

  int n_mismatch, n_results, n_reads, n_writes, n_fills, n_hits, n_misses, n_wbacks;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void push_result(sawc_pkg::kind_t k, logic [31:0] rd, logic h,
                                      logic [25:0] blk, logic [31:0] w, logic l);
    sawc_pkg::result_t r;
    r.kind = k; r.rdata = rd; r.hit = h; r.mem_block = blk; r.mem_word = w; r.last = l;
    expected_results.push_back(r);
  endfunction

  function automatic void complete_access(access_t a, int unsigned line, logic h);
    int unsigned idx;
    idx = line * WORDS + a.addr[5:2];
    if (a.rt == sawc_pkg::REQ_READ) begin
      push_result(sawc_pkg::KIND_READ, shadow_data[idx], h, '0, '0, 1'b1);
    end else begin
      shadow_data[idx] = (shadow_data[idx] & ~a.wmask) | (a.wdata & a.wmask);
      shadow_dirty[line] = 1'b1;
      push_result(sawc_pkg::KIND_WDONE, '0, h, '0, '0, 1'b1);
    end
  endfunction

  function automatic int unsigned set_of(logic [31:0] addr);
    return addr[11:6];
  endfunction

  function automatic void predict_access(access_t a);
    logic [5:0]  set;
    logic [19:0] tag;
    int unsigned line, way;
    logic        b;
    set = a.addr[11:6];
    tag = a.addr[31:12];
    if (miss_busy) begin
      if (a.rt != sawc_pkg::REQ_FILL) return;
      line = set_of(miss_access.addr) * WAYS + miss_way;
      shadow_data[line*WORDS + fill_idx] = a.fill;
      fill_idx++;
      if (fill_idx < WORDS) return;
      fill_idx = 0;
      miss_busy = 1'b0;
      shadow_tag[line] = miss_access.addr[31:12];
      shadow_valid[line] = 1'b1;
      shadow_dirty[line] = 1'b0;
      complete_access(miss_access, line, 1'b0);
      return;
    end
    if (a.rt != sawc_pkg::REQ_READ && a.rt != sawc_pkg::REQ_WRITE) return;
    for (int w = 0; w < WAYS; w++) begin
      line = set * WAYS + w;
      if (shadow_valid[line] && shadow_tag[line] == tag) begin
        n_hits++;
        complete_access(a, line, 1'b1);
        return;
      end
    end
    n_misses++;
    way = WAYS;
    for (int w = WAYS - 1; w >= 0; w--)
      if (!shadow_valid[set*WAYS + w]) way = w;
    if (way == WAYS) begin
      b = victim_lfsr[0] ^ victim_lfsr[2] ^ victim_lfsr[3] ^ victim_lfsr[5];
      victim_lfsr = {b, victim_lfsr[15:1]};
      way = victim_lfsr[1:0];
    end
    line = set * WAYS + way;
    if (shadow_valid[line] && shadow_dirty[line]) begin
      n_wbacks++;
      for (int w = 0; w < WORDS; w++)
        push_result(sawc_pkg::KIND_WBACK, '0, 1'b0, {shadow_tag[line], set},
                    shadow_data[line*WORDS + w], 1'b0);
    end
    shadow_valid[line] = 1'b0;
    shadow_dirty[line] = 1'b0;
    push_result(sawc_pkg::KIND_FETCH, '0, 1'b0, a.addr[31:6], '0, 1'b1);
    miss_busy = 1'b1;
    miss_access = a;
    miss_way = way;
    fill_idx = 0;
  endfunction

  // Driver: sends items in bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      holding = 1'b0;
      gap_left = 0;
      burst_left = 4;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_access(cur_item);
        case (cur_item.rt)
          sawc_pkg::REQ_READ:  n_reads++;
          sawc_pkg::REQ_WRITE: n_writes++;
          sawc_pkg::REQ_FILL:  n_fills++;
          default: ;
        endcase
        holding = 1'b0;
      end
      if (!holding) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_items.size() > 0) begin
          cur_item = pending_items.pop_front();
          holding = 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
          end
        end
      end
      in_ch.valid     <= holding;
      in_ch.req_type  <= cur_item.rt;
      in_ch.addr      <= cur_item.addr;
      in_ch.wdata     <= cur_item.wdata;
      in_ch.wmask     <= cur_item.wmask;
      in_ch.fill_word <= cur_item.fill;
    end
  end

  // Receiver backpressure: alternates between free-running and random stall phases.
  int stall_phase;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_phase = 0;
    end else begin
      stall_phase = (stall_phase + 1) % 96;
      if (stall_phase < 32) out_ch.ready <= 1'b1;
      else if (stall_phase < 64) out_ch.ready <= ($urandom_range(0, 3) != 0);
      else out_ch.ready <= ($urandom_range(0, 2) == 0);
    end
  end

  // Monitor: each result item is checked against the oldest prediction.
  always @(posedge clk) begin
    sawc_pkg::result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_results++;
      if (expected_results.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("unexpected result: kind=%0d rdata=%h", out_ch.kind, out_ch.rdata);
      end else begin
        want = expected_results.pop_front();
        if (out_ch.kind !== want.kind || out_ch.rdata !== want.rdata ||
            out_ch.hit !== want.hit || out_ch.mem_block !== want.mem_block ||
            out_ch.mem_word !== want.mem_word || out_ch.last !== want.last) begin
          n_mismatch++;
          if (n_mismatch <= 10) begin
            $display("mismatch #%0d: exp kind=%0d rdata=%h hit=%b blk=%h word=%h last=%b",
                     n_results, want.kind, want.rdata, want.hit, want.mem_block,
                     want.mem_word, want.last);
            $display("  got kind=%0d rdata=%h hit=%b blk=%h word=%h last=%b",
                     out_ch.kind, out_ch.rdata, out_ch.hit,
                     out_ch.mem_block, out_ch.mem_word, out_ch.last);
          end
        end
      end
    end
  end

  task automatic wait_accepted();
    @(negedge clk);
    while (pending_items.size() > 0 || holding) @(negedge clk);
  endtask

  task automatic drain();
    wait_accepted();
    while (expected_results.size() > 0) @(negedge clk);
  endtask

  task automatic send(sawc_pkg::req_t rt, logic [31:0] addr, logic [31:0] wdata,
                      logic [31:0] wmask, logic [31:0] fill);
    access_t a;
    a.rt = rt; a.addr = addr; a.wdata = wdata; a.wmask = wmask; a.fill = fill;
    pending_items.push_back(a);
  endtask

  // Issues one access; on a miss supplies the refill block, optionally
  // with dropped reads and unused request codes mixed in.
  task automatic access_line(sawc_pkg::req_t rt, logic [31:0] addr, logic [31:0] wdata,
                             logic [31:0] wmask, bit noisy);
    send(rt, addr, wdata, wmask, $urandom);
    wait_accepted();
    if (miss_busy) begin
      for (int w = 0; w < WORDS; w++) begin
        if (noisy && $urandom_range(0, 5) == 0)
          send(sawc_pkg::req_t'($urandom_range(0, 1) ? sawc_pkg::REQ_READ
                                                     : sawc_pkg::REQ_NONE),
               $urandom, $urandom, $urandom, $urandom);
        send(sawc_pkg::REQ_FILL, $urandom, $urandom, $urandom, $urandom);
      end
      wait_accepted();
    end
  endtask

  function automatic logic [31:0] pick_mask();
    case ($urandom_range(0, 3))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [19:0] tag_pool [6];
    logic [5:0]  set;
    int          sent;
    for (int i = 0; i < LINES; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_dirty[i] = 1'b0;
    end
    victim_lfsr = sawc_pkg::LFSR_SEED;
    miss_busy = 1'b0;
    fill_idx = 0;
    holding = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.req_type = sawc_pkg::REQ_NONE;
    in_ch.addr = '0;
    in_ch.wdata = '0;
    in_ch.wmask = '0;
    in_ch.fill_word = '0;
    out_ch.ready = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: idle refill and unused code, cold misses, hits, mask
    // extremes, address extremes, and dirty evictions in set 0.
    send(sawc_pkg::REQ_FILL, 32'h0, 32'h0, 32'h0, 32'hDEAD_BEEF);
    send(sawc_pkg::REQ_NONE, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0);
    access_line(sawc_pkg::REQ_READ, 32'h0000_0000, '0, '0, 1'b0);
    access_line(sawc_pkg::REQ_READ, 32'h0000_003F, '0, '0, 1'b0);
    access_line(sawc_pkg::REQ_WRITE, 32'h0000_0004, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    access_line(sawc_pkg::REQ_WRITE, 32'h0000_0007, 32'h0, 32'h0F0F_0F0F, 1'b0);
    access_line(sawc_pkg::REQ_WRITE, 32'h0000_0004, 32'h1234_5678, 32'h0, 1'b0);
    access_line(sawc_pkg::REQ_READ, 32'h0000_0004, '0, '0, 1'b0);
    access_line(sawc_pkg::REQ_READ, 32'hFFFF_FFFF, '0, '0, 1'b1);
    for (int t = 1; t <= 5; t++)
      access_line(sawc_pkg::REQ_WRITE, {20'(t), 12'h03C}, $urandom, 32'hFFFF_FFFF, 1'b1);
    access_line(sawc_pkg::REQ_READ, 32'h0000_003C, '0, '0, 1'b0);
    drain();

    // Random: a small pool of tags on a few sets so that hits, evictions
    // and dirty writebacks come often; some fully random addresses too.
    foreach (tag_pool[i]) tag_pool[i] = (i == 0) ? 20'h0 : (i == 5) ? 20'hFFFFF : $urandom;
    sent = 0;
    while (sent < 300) begin
      logic [31:0] addr;
      case ($urandom_range(0, 4))
        0: set = 6'd0;
        1: set = 6'd63;
        2: set = 6'd1;
        default: set = $urandom;
      endcase
      if ($urandom_range(0, 4) == 0) addr = $urandom;
      else addr = {tag_pool[$urandom_range(0, 5)], set, 4'($urandom), 2'($urandom)};
      if ($urandom_range(0, 15) == 0)
        send(sawc_pkg::req_t'($urandom_range(0, 1) ? sawc_pkg::REQ_FILL
                                                   : sawc_pkg::REQ_NONE),
             $urandom, $urandom, $urandom, $urandom);
      access_line(sawc_pkg::req_t'($urandom_range(0, 1) ? sawc_pkg::REQ_WRITE
                                                        : sawc_pkg::REQ_READ),
                  addr, $urandom, pick_mask(), $urandom_range(0, 3) == 0);
      sent = n_reads + n_writes + n_fills;
      if ($urandom_range(0, 40) == 0) drain();
    end
    drain();
    repeat (20) @(posedge clk);

    $display("covered %0d reads, %0d writes, %0d refill words",
             n_reads, n_writes, n_fills);
    $display("%0d hits, %0d misses, %0d dirty evictions; checked %0d result items",
             n_hits, n_misses, n_wbacks, n_results);
    if (n_mismatch == 0 && expected_results.size() == 0) begin
      $display("** set_assoc_writeback_cache: PASSED **");
    end else begin
      $display("** set_assoc_writeback_cache: FAILED **");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("timeout with %0d results outstanding", expected_results.size());
    $display("** set_assoc_writeback_cache: FAILED **");
    $finish;
  end
endmodule

### set_assoc_writeback_cache.f
hw/rtl/sawc_pkg.sv
hw/rtl/sawc_if.sv
hw/rtl/sawc_ram.sv
hw/rtl/set_assoc_writeback_cache.sv
hw/rtl/sawc_checker.sv
tb/set_assoc_writeback_cache_tb.sv
